FILE: hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue: action codes, result
// status codes, payload types and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0]      action_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // Action codes carried by an input item.
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_LIST       = 3'd4;

  // Status codes carried by a result item.
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_POP,
    S_LIST
  } dq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels of the double-ended queue: the action channel and
// the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_in_if import dq_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  data_t   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dq_out_if import dq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  data_t   value_out;
  logic    last;

  modport source (output valid, output status, output value_out, output last, input ready);
  modport sink   (input valid, input status, input value_out, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dq_store.sv
// ----------------------------------------------------------------------------
// dq_store
// Entry memory of the queue: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_store import dq_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  data_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output data_t             rd_data
);

  data_t store_r [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // The read register holds its value until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Queue sequencer: front and count registers, memory address generation,
// list walk and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl import dq_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  dq_in_if.sink            in_ch,
  dq_out_if.source         out_ch,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output data_t            wr_data,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  data_t            rd_data
);

  localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W+1)'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  dq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  status_t          pend_status_r, pend_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  data_t            out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] back_pos;
  logic [IDX_W-1:0] tail_pos;
  logic [IDX_W-1:0] walk_pos;

  // Ring position of an offset from the front: one compare and subtract.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, front} + {1'b0, offset};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  // Free slot behind the last entry; used only when the queue is not full.
  assign tail_pos  = ring_pos(front_r, count_r[IDX_W-1:0]);
  // Last held entry; used only when the queue is not empty.
  assign back_pos  = ring_pos(front_r, IDX_W'(count_r - CNT_W'(1)));
  // Next entry of a list walk; idx_r stays below count_r when used.
  assign walk_pos  = ring_pos(front_r, idx_r[IDX_W-1:0]);

  // Memory controls.
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    wr_data     = in_ch.value;
    rd_en       = 1'b0;
    rd_addr     = front_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_PUSH_FRONT: begin
              wr_en   = !is_full;
              wr_addr = front_dec;
            end
            ACT_PUSH_BACK: begin
              wr_en   = !is_full;
            end
            ACT_POP_FRONT, ACT_LIST: begin
              rd_en   = !is_empty;
            end
            ACT_POP_BACK: begin
              rd_en   = !is_empty;
              rd_addr = back_pos;
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (out_free && (idx_r != count_r)) begin
          rd_en   = 1'b1;
          rd_addr = walk_pos;
        end
      end
      default: ;
    endcase
  end

  // Next state, pointers and result register.
  always_comb begin
    logic    imm;
    status_t imm_status;
    logic    load;
    status_t load_status;
    data_t   load_value;
    logic    load_last;

    imm             = 1'b0;
    imm_status      = STAT_OK;
    load            = 1'b0;
    load_status     = STAT_OK;
    load_value      = '0;
    load_last       = 1'b1;
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pend_status_nxt = pend_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              imm = 1'b1;
              if (is_full) begin
                imm_status = STAT_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                if (in_ch.action == ACT_PUSH_FRONT) begin
                  front_nxt = front_dec;
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (is_empty) begin
                imm        = 1'b1;
                imm_status = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (in_ch.action == ACT_POP_FRONT) begin
                  front_nxt = front_inc;
                end
                state_nxt = S_POP;
              end
            end
            ACT_LIST: begin
              if (is_empty) begin
                imm        = 1'b1;
                imm_status = STAT_EMPTY;
              end else begin
                idx_nxt   = CNT_W'(1);
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
        if (imm) begin
          if (out_free) begin
            load        = 1'b1;
            load_status = imm_status;
          end else begin
            pend_status_nxt = imm_status;
            state_nxt       = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load        = 1'b1;
          load_status = pend_status_r;
          state_nxt   = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = rd_data;
          state_nxt  = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = rd_data;
          load_last  = (idx_r == count_r);
          if (idx_r == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = load || (out_valid_r && !out_ch.ready);
    out_status_nxt = load ? load_status : out_status_r;
    out_value_nxt  = load ? load_value  : out_value_r;
    out_last_nxt   = load ? load_last   : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// Each input item carries one action: push front, push back, pop front,
// pop back or list. A push answers with one result, status ok, or status
// full when CAPACITY entries are already held (the value is then dropped).
// A pop answers with the removed value, or status empty. A list streams
// every held value from front to back, one result per entry, and marks the
// final one with last; an empty queue lists as one empty result. Unused
// action codes are accepted and give no result. Timing: a push, or any
// action that finds the queue full or empty, puts its result in the output
// register at the accepting edge when that register is free, so such items
// can follow each other every cycle. A pop's value comes through the
// memory's registered read port. A list issues one read per cycle while the
// output register is free, and each read feeds the next result. The
// block takes one item at a time; ready rises again once the item's last
// result has entered the output register, and that register lets a new item
// in while the result still waits for the consumer. Store entries are never
// read before they are written, so the memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  // Ring index covers CAPACITY slots; the count also reaches CAPACITY.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  data_t            wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  data_t            rd_data;

  // The sequencer owns the front index, the entry count and the result
  // register. Writes and reads of the memory happen for different items in
  // different cycles, so a pop right after a push sees the pushed value.
  dq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Entry memory: one write port, one registered read port.
  dq_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
